// ===== rtl/bate_pkg.sv =====
// shared types, codes and constants for the block allocation table engine
package bate_pkg;

	// table geometry and marker values
	localparam int unsigned TABLE_ENTRIES_DEF = 256;
	localparam int unsigned LINK_W            = 16;
	localparam logic [15:0] FREE_MARK         = 16'hfffc;

	// configuration register map
	localparam int unsigned CFG_IDX_W         = 1;
	localparam int unsigned CFG_DATA_W        = 16;
	localparam int unsigned TLIMIT_W          = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LEN    = 1'd1;
	localparam logic [TLIMIT_W-1:0]  TABLE_LIMIT_RST = 9'd256;
	localparam logic [15:0]          SCAN_LEN_RST    = 16'd256;

	// request codes
	typedef enum logic [2:0] {
		OP_READ      = 3'd0,
		OP_WRITE     = 3'd1,
		OP_COUNT     = 3'd2,
		OP_FIND      = 3'd3,
		OP_CLR_DIRTY = 3'd4
	} req_op_t;

	// one request word
	typedef struct packed {
		req_op_t     op;
		logic [15:0] index;
		logic [15:0] value;
	} req_t;

	// one result word
	typedef struct packed {
		logic [15:0] read_value;
		logic [15:0] free_count;
		logic [15:0] found_block;
		logic        dirty;
	} res_t;

endpackage

// ===== rtl/bate_ram.sv =====
// generic single-port ram with registered read
module bate_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read on one port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bate_ctrl.sv =====
// sequencer: clearing pass, entry access and the shared free-entry scan unit
module bate_ctrl
	import bate_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  req_t                             req,
	output logic                             ready,
	input  logic [15:0]                      lim,
	input  logic [15:0]                      scan_len,
	input  logic                             out_free,
	output logic                             res_vld,
	output res_t                             res,
	output logic [$clog2(TABLE_ENTRIES)-1:0] ram_addr,
	output logic                             ram_we,
	output logic [LINK_W-1:0]                ram_wdata,
	input  logic [LINK_W-1:0]                ram_rdata
);

	localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES);
	localparam int unsigned LIM_W  = $clog2(TABLE_ENTRIES + 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_RDATA,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;
	req_op_t           op_q;
	logic [15:0]       idx_q;
	logic [15:0]       val_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LIM_W-1:0]  left_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] pidx_s1;
	logic [15:0]       rd_q;
	logic [15:0]       cnt_q;
	logic [15:0]       found_q;
	logic              dirty_q;

	logic              in_range;
	logic              nb_below;
	logic [15:0]       scan_n;
	logic [15:0]       extra;
	logic [15:0]       nb_m1;
	logic              hit;

	// limits of the scan: blocks past the table limit are free by definition
	assign in_range = idx_q < lim;
	assign nb_below = scan_len <= lim;
	assign scan_n   = nb_below ? scan_len : lim;
	assign extra    = scan_len - scan_n;
	assign nb_m1    = scan_len - 16'd1;
	assign hit      = pend_s1 && (ram_rdata == FREE_MARK);

	// memory port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = val_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = FREE_MARK;
			end
			S_EXEC: begin
				ram_addr = idx_q[ADDR_W-1:0];
				ram_we   = (op_q == OP_WRITE) && in_range;
			end
			default: begin
				ram_addr = addr_q;
			end
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q  <= '0;
			left_q  <= '0;
			pend_s1 <= 1'b0;
			dirty_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= req.op;
						idx_q   <= req.index;
						val_q   <= req.value;
						rd_q    <= '0;
						cnt_q   <= '0;
						found_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					pend_s1 <= 1'b0;
					unique case (op_q)
						OP_READ: begin
							if (in_range) begin
								state_q <= S_RDATA;
							end else begin
								rd_q    <= FREE_MARK;
								state_q <= S_DONE;
							end
						end
						OP_WRITE: begin
							if (in_range) begin
								dirty_q <= 1'b1;
							end
							state_q <= S_DONE;
						end
						OP_COUNT: begin
							cnt_q   <= extra;
							left_q  <= LIM_W'(scan_n);
							addr_q  <= '0;
							state_q <= S_SCAN;
						end
						OP_FIND: begin
							if (scan_len == 16'd0) begin
								found_q <= FREE_MARK;
								state_q <= S_DONE;
							end else if (!nb_below) begin
								found_q <= nb_m1;
								state_q <= S_DONE;
							end else begin
								left_q  <= LIM_W'(scan_len);
								addr_q  <= nb_m1[ADDR_W-1:0];
								state_q <= S_SCAN;
							end
						end
						OP_CLR_DIRTY: begin
							dirty_q <= 1'b0;
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_RDATA: begin
					rd_q    <= ram_rdata;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					// issue one read a cycle, check the word read last cycle
					if (left_q != '0) begin
						left_q  <= left_q - 1'b1;
						addr_q  <= (op_q == OP_FIND) ? addr_q - 1'b1 : addr_q + 1'b1;
						pend_s1 <= 1'b1;
						pidx_s1 <= addr_q;
					end else begin
						pend_s1 <= 1'b0;
					end
					priority if (hit && (op_q == OP_FIND)) begin
						found_q <= 16'(pidx_s1);
						state_q <= S_DONE;
					end else if (hit) begin
						cnt_q <= cnt_q + 16'd1;
					end else if ((left_q == '0) && !pend_s1) begin
						if (op_q == OP_FIND) begin
							found_q <= FREE_MARK;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result hand-off
	assign ready   = (state_q == S_IDLE);
	assign res_vld = (state_q == S_DONE) && out_free;
	assign res     = '{read_value: rd_q, free_count: cnt_q, found_block: found_q,
		dirty: dirty_q};

endmodule

// ===== rtl/block_allocation_table_engine_unit.sv =====
// Block allocation table engine: a table of 16-bit chain links (0xfffc = free
// block) with read, write (sets the dirty mark when in range), count-free,
// find-highest-free and clear-dirty requests, one result word per request. After
// reset the table is swept to the free marker, one entry per cycle; s_tready
// stays low until the sweep ends (configuration writes are taken at any time).
// A count walks min(scan length, limit) entries and a find up to that many, since
// both walk the single memory port one entry per cycle; one request is in work
// at a time and the next is taken once the result sits in the output register.
module block_allocation_table_engine_unit
	import bate_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request words
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,  // index[15:0], value[31:16]
	input  logic [2:0]            s_tuser,  // req_type[2:0]
	// result words
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,  // read_value, free_count, found_block, dirty, pad
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES);

	logic [TLIMIT_W-1:0] table_limit_q;
	logic [15:0]         scan_len_q;
	logic [15:0]         lim;
	logic [15:0]         tl_ext;
	req_t                req;
	res_t                res;
	logic                res_vld;
	logic                out_free;
	logic                m_tvalid_q;
	logic [55:0]         m_tdata_q;
	logic [ADDR_W-1:0]   ram_addr;
	logic                ram_we;
	logic [LINK_W-1:0]   ram_wdata;
	logic [LINK_W-1:0]   ram_rdata;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_limit_q <= TABLE_LIMIT_RST;
			scan_len_q    <= SCAN_LEN_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_TABLE_LIMIT) begin
				table_limit_q <= cfg_data[TLIMIT_W-1:0];
			end
			if (cfg_index == CFG_SCAN_LEN) begin
				scan_len_q <= cfg_data;
			end
		end
	end

	// effective limit is capped at the table depth
	assign tl_ext = 16'(table_limit_q);
	assign lim    = (tl_ext > 16'(TABLE_ENTRIES)) ? 16'(TABLE_ENTRIES) : tl_ext;

	// request unpacking
	assign req = '{op: req_op_t'(s_tuser), index: s_tdata[15:0], value: s_tdata[31:16]};

	bate_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (s_tvalid && s_tready),
		.req        (req),
		.ready      (s_tready),
		.lim        (lim),
		.scan_len   (scan_len_q),
		.out_free   (out_free),
		.res_vld    (res_vld),
		.res        (res),
		.ram_addr   (ram_addr),
		.ram_we     (ram_we),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata)
	);

	bate_ram #(
		.WIDTH(LINK_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// output register
	assign out_free = !m_tvalid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_vld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			m_tdata_q <= {7'd0, res.dirty, res.found_block, res.free_count, res.read_value};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/bate_checker.sv =====
// port-level checks for the block allocation table engine, bound to the top level
module bate_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// one request in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while the previous one is in work");

	// a result appears only as a request completes
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result word appeared with no request in work");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// each request fills at most one of the value fields
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] == 16'd0 || (m_tdata[31:16] == 16'd0 &&
		m_tdata[47:32] == 16'd0)) && (m_tdata[31:16] == 16'd0 || m_tdata[47:32] == 16'd0))
		else $error("more than one result field set");

endmodule

bind block_allocation_table_engine_unit bate_checker u_chk (.*);

// ===== verif/tb_block_allocation_table_engine_unit.sv =====
// self-checking testbench for the block allocation table engine: queued requests, predicted results
module tb_block_allocation_table_engine_unit
	import bate_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no accepted word before the run is declared hung
	localparam int unsigned STALL_LIMIT = 4000;

	// one request word waiting for the driver
	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] index;
		logic [15:0] value;
	} bat_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;
	logic [2:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [55:0]           m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// stimulus and expectation stores
	bat_req_t    pend_reqs[$];
	res_t        want_results[$];
	int unsigned err_count = 0;
	int unsigned quiet_cycles = 0;
	bit          req_taken = 1'b0;
	int unsigned idle_mode = 0;

	// predictor state: link table, dirty mark and the two registers
	logic [15:0]         links[TABLE_ENTRIES_DEF];
	logic                dirty_mark;
	logic [TLIMIT_W-1:0] tbl_limit;
	logic [15:0]         scan_blocks;

	block_allocation_table_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_limit();
		return (tbl_limit > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : int'(tbl_limit);
	endfunction

	// blocks at or above the limit read as free
	function automatic logic [15:0] link_at(int unsigned i);
		if (i >= eff_limit())
			return FREE_MARK;
		return links[i];
	endfunction

	// apply one request to the table copy and give its result word
	function automatic res_t predict_result(logic [2:0] op, logic [15:0] idx, logic [15:0] val);
		res_t        r;
		int unsigned i;
		r = '0;
		case (op)
			OP_READ: begin
				r.read_value = link_at(idx);
			end
			OP_WRITE: begin
				if (idx < eff_limit()) begin
					links[idx] = val;
					dirty_mark = 1'b1;
				end
			end
			OP_COUNT: begin
				for (i = 0; i < scan_blocks; i++)
					if (link_at(i) == FREE_MARK)
						r.free_count = r.free_count + 16'd1;
			end
			OP_FIND: begin
				r.found_block = FREE_MARK;
				for (i = scan_blocks; i > 0; i--) begin
					if (link_at(i - 1) == FREE_MARK) begin
						r.found_block = 16'(i - 1);
						break;
					end
				end
			end
			OP_CLR_DIRTY: begin
				dirty_mark = 1'b0;
			end
			default: ;
		endcase
		r.dirty = dirty_mark;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic bit stall_now(int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// request driver, holds a word until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (pend_reqs.size() != 0 &&
			    !stall_now(idle_mode == 1 ? 55 : (idle_mode == 3 ? 20 : 0))) begin
				s_tvalid <= 1'b1;
				s_tuser  <= pend_reqs[0].op;
				s_tdata  <= {pend_reqs[0].value, pend_reqs[0].index};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		m_tready <= !stall_now(idle_mode == 2 ? 55 : (idle_mode == 3 ? 20 : 0));
	end

	// result checker, predictor on accepted requests, watchdog
	always @(posedge clk) begin
		res_t want;
		req_taken = s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			if (want_results.size() == 0) begin
				report_mismatch("unexpected result word", m_tdata[15:0], 16'h0);
			end else begin
				want = want_results.pop_front();
				if (m_tdata[15:0] !== want.read_value)
					report_mismatch("read_value", m_tdata[15:0], want.read_value);
				if (m_tdata[31:16] !== want.free_count)
					report_mismatch("free_count", m_tdata[31:16], want.free_count);
				if (m_tdata[47:32] !== want.found_block)
					report_mismatch("found_block", m_tdata[47:32], want.found_block);
				if (m_tdata[48] !== want.dirty)
					report_mismatch("dirty", {15'h0, m_tdata[48]}, {15'h0, want.dirty});
			end
		end
		if (req_taken) begin
			want_results.push_back(predict_result(s_tuser, s_tdata[15:0], s_tdata[31:16]));
			void'(pend_reqs.pop_front());
		end
		if (req_taken || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[block_allocation_table_engine_unit] ERROR");
			$finish;
		end
	end

	task automatic push_req(logic [2:0] op, logic [15:0] idx, logic [15:0] val);
		bat_req_t r;
		r.op = op;
		r.index = idx;
		r.value = val;
		pend_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pend_reqs.size() != 0 || want_results.size() != 0)
			@(posedge clk);
	endtask

	// register write, predictor follows on the accepted word
	task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [15:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		if (ri == CFG_TABLE_LIMIT)
			tbl_limit = d[TLIMIT_W-1:0];
		else
			scan_blocks = d;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly near the limit, sometimes anywhere in the 16-bit range
	function automatic logic [15:0] pick_index(int unsigned lim);
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return 16'($urandom_range(0, lim + 4));
		if (p < 85)
			return 16'($urandom);
		return (p < 92) ? 16'(lim - 1) : 16'(lim);
	endfunction

	function automatic logic [15:0] pick_value();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 35)
			return FREE_MARK;
		if (p < 50)
			return 16'hfffa;
		if (p < 55)
			return 16'hffff;
		if (p < 60)
			return 16'h0000;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] used_value();
		logic [15:0] v;
		v = 16'($urandom);
		return (v == FREE_MARK) ? 16'hfffa : v;
	endfunction

	// random traffic: chains of writes with read-back, scans, fills, noise
	task automatic gen_random(int unsigned n);
		int unsigned k, pick, lim, j;
		logic [15:0] ix;
		lim = eff_limit();
		k = 0;
		while (k < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 8 && lim <= 32) begin
				// occupy every entry, then scan a full table
				for (j = 0; j < lim; j++)
					push_req(OP_WRITE, 16'(j), used_value());
				push_req(OP_COUNT, 16'($urandom), 16'($urandom));
				push_req(OP_FIND, 16'($urandom), 16'($urandom));
				k += lim + 2;
			end else if (pick < 40) begin
				ix = pick_index(lim);
				push_req(OP_WRITE, ix, pick_value());
				push_req(OP_READ, ix, 16'($urandom));
				k += 2;
			end else if (pick < 55) begin
				push_req(OP_READ, pick_index(lim), 16'($urandom));
				k++;
			end else if (pick < 67) begin
				push_req(OP_COUNT, 16'($urandom), 16'($urandom));
				k++;
			end else if (pick < 79) begin
				push_req(OP_FIND, 16'($urandom), 16'($urandom));
				k++;
			end else if (pick < 85) begin
				push_req(OP_CLR_DIRTY, 16'($urandom), 16'($urandom));
				k++;
			end else if (pick < 90) begin
				push_req(3'(OP_CLR_DIRTY + 1 + $urandom_range(0, 2)), 16'($urandom),
				         16'($urandom));
				k++;
			end else begin
				// free or take a block and look at the scans right after
				push_req(OP_WRITE, pick_index(lim), pick_value());
				push_req(OP_COUNT, 16'($urandom), 16'($urandom));
				push_req(OP_FIND, 16'($urandom), 16'($urandom));
				k += 3;
			end
		end
	endtask

	task automatic run_phase(int unsigned mode, logic [15:0] lim_d, logic [15:0] nb_d,
	                         int unsigned n);
		drain();
		write_reg(CFG_TABLE_LIMIT, lim_d);
		write_reg(CFG_SCAN_LEN, nb_d);
		idle_mode = mode;
		gen_random(n);
		drain();
	endtask

	// sequence of the run
	initial begin
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
			links[i] = FREE_MARK;
		dirty_mark  = 1'b0;
		tbl_limit   = TABLE_LIMIT_RST;
		scan_blocks = SCAN_LEN_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset table, bounds, every request code
		push_req(OP_READ, 16'd0, 16'h0000);
		push_req(OP_READ, 16'd255, 16'hffff);
		push_req(OP_READ, 16'd256, 16'h0000);
		push_req(OP_READ, 16'hffff, 16'hffff);
		push_req(OP_COUNT, 16'h0000, 16'h0000);
		push_req(OP_FIND, 16'hffff, 16'hffff);
		push_req(OP_WRITE, 16'd0, 16'hfffa);
		push_req(OP_WRITE, 16'd255, 16'h0000);
		push_req(OP_WRITE, 16'hffff, 16'hffff);
		push_req(OP_WRITE, 16'd256, 16'h1234);
		push_req(OP_READ, 16'd0, 16'h0000);
		push_req(OP_READ, 16'd255, 16'h0000);
		push_req(OP_COUNT, 16'h0000, 16'h0000);
		push_req(OP_FIND, 16'h0000, 16'h0000);
		push_req(OP_CLR_DIRTY, 16'hffff, 16'hffff);
		push_req(OP_WRITE, 16'd300, 16'h5555);
		push_req(OP_WRITE, 16'd10, FREE_MARK);
		push_req(OP_CLR_DIRTY, 16'h0000, 16'h0000);
		push_req(3'(OP_CLR_DIRTY + 1), 16'hffff, 16'hffff);
		push_req(3'(OP_CLR_DIRTY + 2), 16'h0000, 16'h0000);
		push_req(3'(OP_CLR_DIRTY + 3), 16'hffff, 16'hffff);
		push_req(OP_WRITE, 16'd100, 16'hffff);
		push_req(OP_READ, 16'd100, 16'h0000);
		drain();

		// random phases over several register settings and idling patterns
		run_phase(0, 16'd256, 16'd256, 150);
		run_phase(1, 16'd16, 16'd16, 150);
		run_phase(2, 16'hfeff, 16'hffff, 150);
		run_phase(3, 16'hffff, 16'd300, 150);
		run_phase(1, 16'h0000, 16'd40, 100);
		run_phase(2, 16'd24, 16'h0000, 60);
		run_phase(0, 16'd100, 16'd90, 140);

		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("[block_allocation_table_engine_unit] OK");
		else
			$display("[block_allocation_table_engine_unit] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bate_pkg.sv
rtl/bate_ram.sv
rtl/bate_ctrl.sv
rtl/block_allocation_table_engine_unit.sv
rtl/bate_checker.sv
verif/tb_block_allocation_table_engine_unit.sv
